[hw/rtl/shared_exclusive_lock_manager_unit_defines.svh]
// assertion macros used by the checker file
`ifndef SHARED_EXCLUSIVE_LOCK_MANAGER_UNIT_DEFINES_SVH
`define SHARED_EXCLUSIVE_LOCK_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define SELM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masked
`define SELM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/selm_pkg.sv]
// ----------------------------------------------------------------------------
// selm_pkg
// types and codes of the shared/exclusive lock manager
// ----------------------------------------------------------------------------
package selm_pkg;

   localparam int TXN_W     = 6;
   localparam int KEY_W     = 32;
   localparam int WAIT_W    = 4;
   localparam int CAP_W     = 4;
   localparam logic [CAP_W-1:0]  RESULT_CAP = 4'd8;
   localparam logic [WAIT_W-1:0] WAIT_MAX   = 4'd15;

   localparam logic [1:0] CMD_READ    = 2'd0;
   localparam logic [1:0] CMD_WRITE   = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_STATUS  = 2'd3;

   localparam logic [1:0] KIND_LOCK   = 2'd0;
   localparam logic [1:0] KIND_READY  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_SHARED = 2'd1;
   localparam logic [1:0] MODE_EXCL   = 2'd2;

   localparam logic [1:0] ERR_OK         = 2'd0;
   localparam logic [1:0] ERR_TABLE_FULL = 2'd1;
   localparam logic [1:0] ERR_QUEUE_FULL = 2'd2;

   typedef struct packed {
      logic             excl;
      logic [TXN_W-1:0] txn;
   } qentry_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             granted;
      logic [TXN_W-1:0] owner;
      logic [1:0]       mode;
      logic [1:0]       err;
      logic             last;
   } item_type;

endpackage

[hw/rtl/shared_exclusive_lock_manager_unit.sv]
// ----------------------------------------------------------------------------
// shared_exclusive_lock_manager_unit
// lock table with a fifo request queue per key, shared and exclusive modes
// ----------------------------------------------------------------------------
// usage:
//   request channel (req_*): cmd 0 read lock, 1 write lock, 2 release,
//   3 status query, with txn id and 32-bit key; taken when req_valid is high
//   and req_stall low. req_stall stays high while a request is in work.
//   response channel (rsp_*): lock replies, ready notices and status
//   entries; rsp_last marks the final response of a request. a release may
//   produce no response at all.
//   search: the key table is searched one slot at a time, each slot first
//   read and then checked; read locks, status queries and releases walk the
//   queue entry by entry, a release adds a second pass over the remaining
//   entries, and each wait counter update is a read and then a write.
//   the response register lets the next request enter while the last
//   response still waits; a stalled receiver holds the block whenever a
//   response must move into the response register while it is still full.
//   reset: a clearing pass zeroes the queue counts and wait counters;
//   req_stall is high meanwhile.
// ----------------------------------------------------------------------------
module shared_exclusive_lock_manager_unit #(
   parameter int KEY_SLOTS   = 16,
   parameter int QUEUE_DEPTH = 8,
   parameter int TXN_SLOTS   = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [selm_pkg::TXN_W-1:0]  req_txn_id,
   input  logic [selm_pkg::KEY_W-1:0]  req_lock_key,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic                        rsp_granted,
   output logic [selm_pkg::TXN_W-1:0]  rsp_owner_txn,
   output logic [1:0]                  rsp_lock_mode,
   output logic [1:0]                  rsp_error,
   output logic                        rsp_last
);

   localparam int KA    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam int WA    = $clog2(TXN_SLOTS);
   localparam int QN    = KEY_SLOTS * QUEUE_DEPTH;
   localparam int QA    = (QN > 1) ? $clog2(QN) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int PV    = 1 << CW;
   localparam int CLR_N = (KEY_SLOTS > TXN_SLOTS) ? KEY_SLOTS : TXN_SLOTS;
   localparam int CLW   = $clog2(CLR_N);
   localparam int TW    = CW + selm_pkg::KEY_W;
   localparam int TXW   = selm_pkg::TXN_W;
   localparam int WW    = selm_pkg::WAIT_W;

   typedef enum logic [14:0] {
      ST_CLEAR = 15'b000000000000001,
      ST_IDLE  = 15'b000000000000010,
      ST_KRD   = 15'b000000000000100,
      ST_KCHK  = 15'b000000000001000,
      ST_SETUP = 15'b000000000010000,
      ST_NEW   = 15'b000000000100000,
      ST_QRD   = 15'b000000001000000,
      ST_QCHK  = 15'b000000010000000,
      ST_LWR   = 15'b000000100000000,
      ST_RCNT  = 15'b000001000000000,
      ST_PRD   = 15'b000010000000000,
      ST_PCHK  = 15'b000100000000000,
      ST_WRD   = 15'b001000000000000,
      ST_WCHK  = 15'b010000000000000,
      ST_FIN   = 15'b100000000000000
   } state_type;

   // memories: key table {count, tag}, request queues, wait counters
   logic [TW-1:0]             tag_mem_ff   [KEY_SLOTS];
   selm_pkg::qentry_type      queue_mem_ff [QN];
   logic [WW-1:0]             wait_mem_ff  [TXN_SLOTS];

   logic                      tm_re, tm_we, qm_re, qm_we, wm_re, wm_we;
   logic [KA-1:0]             tm_wa;
   logic [TW-1:0]             tm_wd, tm_q_ff;
   logic [QA-1:0]             qm_ra, qm_wa;
   selm_pkg::qentry_type      qm_wd, qm_q_ff;
   logic [WA-1:0]             wm_ra, wm_wa;
   logic [WW-1:0]             wm_wd, wm_q_ff;

   state_type                 state_ff, state_in;
   logic [CLW-1:0]            clr_ff, clr_in;
   logic [1:0]                cmd_ff, cmd_in;
   logic [TXW-1:0]            txn_ff, txn_in;
   logic [selm_pkg::KEY_W-1:0] key_ff, key_in;
   logic [KA-1:0]             scan_ff, scan_in, fslot_ff, fslot_in, free_ff, free_in;
   logic                      found_ff, found_in, free_v_ff, free_v_in;
   logic [CW-1:0]             cnt_ff, cnt_in, idx_ff, idx_in, widx_ff, widx_in;
   logic [QA-1:0]             base_ff, base_in;
   logic                      ok_ff, ok_in, sh_ff, sh_in;
   logic [PV-1:0]             prev_ff, prev_in;
   logic [TXW-1:0]            cur_ff, cur_in;
   logic                      pend_v_ff, pend_v_in;
   selm_pkg::item_type        pend_ff, pend_in;
   logic [selm_pkg::CAP_W-1:0] ecnt_ff, ecnt_in;

   // response path
   logic                      offer_v, push, can_push, can_offer;
   selm_pkg::item_type        offer_item, push_item;

   logic [CW-1:0]             tm_cnt;
   logic [KA-1:0]             slot_sel;
   logic                      before_r, after_i, idx_end;
   logic [WW-1:0]             wc_dec;

   function automatic logic txn_ok(input logic [TXW-1:0] t);
      return 32'(t) < 32'(TXN_SLOTS);
   endfunction

   function automatic selm_pkg::item_type mk_item(input logic [1:0] kind,
      input logic granted, input logic [TXW-1:0] owner, input logic [1:0] mode,
      input logic [1:0] err);
      selm_pkg::item_type it;
      it.kind    = kind;
      it.granted = granted;
      it.owner   = owner;
      it.mode    = mode;
      it.err     = err;
      it.last    = 1'b0;
      return it;
   endfunction

   // memory ports
   always_ff @(posedge clock) begin
      if (tm_we) begin
         tag_mem_ff[tm_wa] <= tm_wd;
      end
      if (tm_re) begin
         tm_q_ff <= tag_mem_ff[scan_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (qm_we) begin
         queue_mem_ff[qm_wa] <= qm_wd;
      end
      if (qm_re) begin
         qm_q_ff <= queue_mem_ff[qm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (wm_we) begin
         wait_mem_ff[wm_wa] <= wm_wd;
      end
      if (wm_re) begin
         wm_q_ff <= wait_mem_ff[wm_ra];
      end
   end

   assign tm_cnt    = tm_q_ff[TW-1 -: CW];
   assign slot_sel  = found_ff ? fslot_ff : free_ff;
   assign qm_ra     = base_ff + QA'(idx_ff);
   assign wm_ra     = WA'(cur_ff);
   assign idx_end   = (CW'(idx_ff + 1'b1) == cnt_ff);
   // holder before release: front entry, or inside the leading shared run
   assign before_r  = (idx_ff == '0) || (sh_ff && !qm_q_ff.excl);
   assign after_i   = before_r;
   assign wc_dec    = wm_q_ff - 1'b1;
   assign can_offer = (ecnt_ff >= selm_pkg::RESULT_CAP) || !pend_v_ff || can_push;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      txn_in    = txn_ff;
      key_in    = key_ff;
      scan_in   = scan_ff;
      fslot_in  = fslot_ff;
      free_in   = free_ff;
      found_in  = found_ff;
      free_v_in = free_v_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      widx_in   = widx_ff;
      base_in   = base_ff;
      ok_in     = ok_ff;
      sh_in     = sh_ff;
      prev_in   = prev_ff;
      cur_in    = cur_ff;
      tm_re = 1'b0; tm_we = 1'b0; tm_wa = '0; tm_wd = '0;
      qm_re = 1'b0; qm_we = 1'b0; qm_wa = '0; qm_wd = '0;
      wm_re = 1'b0; wm_we = 1'b0; wm_wa = '0; wm_wd = '0;
      offer_v    = 1'b0;
      offer_item = mk_item(selm_pkg::KIND_LOCK, 1'b0, txn_ff, selm_pkg::MODE_NONE,
                           selm_pkg::ERR_OK);

      unique case (state_ff)
         ST_CLEAR: begin
            // zero queue counts and wait counters after reset
            if (32'(clr_ff) < 32'(KEY_SLOTS)) begin
               tm_we = 1'b1;
               tm_wa = clr_ff[KA-1:0];
            end
            if (32'(clr_ff) < 32'(TXN_SLOTS)) begin
               wm_we = 1'b1;
               wm_wa = clr_ff[WA-1:0];
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLW'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               txn_in    = req_txn_id;
               key_in    = req_lock_key;
               scan_in   = '0;
               found_in  = 1'b0;
               free_v_in = 1'b0;
               state_in  = ST_KRD;
            end
         end
         ST_KRD: begin
            tm_re    = 1'b1;
            state_in = ST_KCHK;
         end
         ST_KCHK: begin
            // an entry with a nonzero count is a live key
            if (tm_cnt != '0 && tm_q_ff[selm_pkg::KEY_W-1:0] == key_ff) begin
               found_in = 1'b1;
               fslot_in = scan_ff;
               cnt_in   = tm_cnt;
               state_in = ST_SETUP;
            end else begin
               if (tm_cnt == '0 && !free_v_ff) begin
                  free_v_in = 1'b1;
                  free_in   = scan_ff;
               end
               if (scan_ff == KA'(KEY_SLOTS - 1)) begin
                  state_in = ST_SETUP;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = ST_KRD;
               end
            end
         end
         ST_SETUP: begin
            base_in  = QA'(slot_sel) * QA'(QUEUE_DEPTH);
            idx_in   = '0;
            widx_in  = '0;
            sh_in    = 1'b1;
            ok_in    = 1'b1;
            state_in = ST_FIN;
            case (cmd_ff)
               selm_pkg::CMD_READ, selm_pkg::CMD_WRITE: begin
                  if (!found_ff) begin
                     if (!free_v_ff) begin
                        offer_v    = 1'b1;
                        offer_item = mk_item(selm_pkg::KIND_LOCK, 1'b0, txn_ff,
                                     selm_pkg::MODE_NONE, selm_pkg::ERR_TABLE_FULL);
                     end else begin
                        state_in = ST_NEW;
                     end
                  end else if (32'(cnt_ff) >= 32'(QUEUE_DEPTH)) begin
                     offer_v    = 1'b1;
                     offer_item = mk_item(selm_pkg::KIND_LOCK, 1'b0, txn_ff,
                                  selm_pkg::MODE_NONE, selm_pkg::ERR_QUEUE_FULL);
                  end else if (cmd_ff == selm_pkg::CMD_WRITE) begin
                     ok_in    = 1'b0;
                     state_in = ST_LWR;
                  end else begin
                     state_in = ST_QRD;
                  end
               end
               selm_pkg::CMD_STATUS: begin
                  if (!found_ff) begin
                     offer_v    = 1'b1;
                     offer_item = mk_item(selm_pkg::KIND_STATUS, 1'b0, '0,
                                  selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
                  end else begin
                     state_in = ST_QRD;
                  end
               end
               default: begin
                  if (found_ff) begin
                     state_in = ST_QRD;
                  end
               end
            endcase
         end
         ST_NEW: begin
            tm_we = 1'b1;
            tm_wa = free_ff;
            tm_wd = {CW'(1), key_ff};
            qm_we = 1'b1;
            qm_wa = base_ff;
            qm_wd = '{excl: (cmd_ff == selm_pkg::CMD_WRITE), txn: txn_ff};
            offer_v    = 1'b1;
            offer_item = mk_item(selm_pkg::KIND_LOCK, 1'b1, txn_ff,
                                 selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
            state_in   = ST_FIN;
         end
         ST_QRD: begin
            qm_re    = 1'b1;
            state_in = ST_QCHK;
         end
         ST_QCHK: begin
            case (cmd_ff)
               selm_pkg::CMD_READ, selm_pkg::CMD_WRITE: begin
                  if (qm_q_ff.excl) begin
                     ok_in = 1'b0;
                  end
                  if (idx_end) begin
                     state_in = ST_LWR;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_QRD;
                  end
               end
               selm_pkg::CMD_STATUS: begin
                  if (qm_q_ff.excl) begin
                     if (idx_ff == '0) begin
                        offer_v    = 1'b1;
                        offer_item = mk_item(selm_pkg::KIND_STATUS, 1'b0,
                                     qm_q_ff.txn, selm_pkg::MODE_EXCL, selm_pkg::ERR_OK);
                     end
                     state_in = ST_FIN;
                  end else if (can_offer) begin
                     offer_v    = 1'b1;
                     offer_item = mk_item(selm_pkg::KIND_STATUS, 1'b0, qm_q_ff.txn,
                                  selm_pkg::MODE_SHARED, selm_pkg::ERR_OK);
                     if (idx_end) begin
                        state_in = ST_FIN;
                     end else begin
                        idx_in   = idx_ff + 1'b1;
                        state_in = ST_QRD;
                     end
                  end
               end
               default: begin
                  // release, first pass: compact the queue in place
                  sh_in = sh_ff && !qm_q_ff.excl;
                  if (qm_q_ff.txn != txn_ff) begin
                     qm_we            = 1'b1;
                     qm_wa            = base_ff + QA'(widx_ff);
                     qm_wd            = qm_q_ff;
                     prev_in[widx_ff] = before_r;
                     widx_in          = widx_ff + 1'b1;
                  end
                  if (idx_end) begin
                     state_in = ST_RCNT;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = ST_QRD;
                  end
               end
            endcase
         end
         ST_LWR: begin
            qm_we = 1'b1;
            qm_wa = base_ff + QA'(cnt_ff);
            qm_wd = '{excl: (cmd_ff == selm_pkg::CMD_WRITE), txn: txn_ff};
            tm_we = 1'b1;
            tm_wa = fslot_ff;
            tm_wd = {CW'(cnt_ff + 1'b1), key_ff};
            if (!ok_ff && txn_ok(txn_ff)) begin
               cur_in   = txn_ff;
               state_in = ST_WRD;
            end else begin
               offer_v    = 1'b1;
               offer_item = mk_item(selm_pkg::KIND_LOCK, ok_ff, txn_ff,
                                    selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
               state_in   = ST_FIN;
            end
         end
         ST_RCNT: begin
            tm_we  = 1'b1;
            tm_wa  = fslot_ff;
            tm_wd  = {widx_ff, key_ff};
            cnt_in = widx_ff;
            idx_in = '0;
            sh_in  = 1'b1;
            state_in = (widx_ff == '0) ? ST_FIN : ST_PRD;
         end
         ST_PRD: begin
            qm_re    = 1'b1;
            state_in = ST_PCHK;
         end
         ST_PCHK: begin
            // second pass: new holders that were not holders before
            sh_in = sh_ff && !qm_q_ff.excl;
            if (!after_i) begin
               state_in = ST_FIN;
            end else if (!prev_ff[idx_ff] && txn_ok(qm_q_ff.txn)) begin
               cur_in   = qm_q_ff.txn;
               state_in = ST_WRD;
            end else if (idx_end) begin
               state_in = ST_FIN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PRD;
            end
         end
         ST_WRD: begin
            wm_re    = 1'b1;
            state_in = ST_WCHK;
         end
         ST_WCHK: begin
            if (cmd_ff != selm_pkg::CMD_RELEASE) begin
               wm_we = 1'b1;
               wm_wa = WA'(cur_ff);
               wm_wd = (wm_q_ff == selm_pkg::WAIT_MAX) ? wm_q_ff : wm_q_ff + 1'b1;
               offer_v    = 1'b1;
               offer_item = mk_item(selm_pkg::KIND_LOCK, 1'b0, txn_ff,
                                    selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
               state_in   = ST_FIN;
            end else if (wm_q_ff != WW'(1) || can_offer) begin
               if (wm_q_ff != '0) begin
                  wm_we = 1'b1;
                  wm_wa = WA'(cur_ff);
                  wm_wd = wc_dec;
               end
               if (wm_q_ff == WW'(1)) begin
                  offer_v    = 1'b1;
                  offer_item = mk_item(selm_pkg::KIND_READY, 1'b0, cur_ff,
                                       selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
               end
               if (idx_end) begin
                  state_in = ST_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_PRD;
               end
            end
         end
         ST_FIN: begin
            if (!pend_v_ff || can_push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // one response is held back until we know whether it is the last one
   always_comb begin
      push      = 1'b0;
      push_item = pend_ff;
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      ecnt_in   = ecnt_ff;
      if (state_ff == ST_IDLE) begin
         ecnt_in   = '0;
         pend_v_in = 1'b0;
      end else if (state_ff == ST_FIN) begin
         if (pend_v_ff && can_push) begin
            push           = 1'b1;
            push_item.last = 1'b1;
            pend_v_in      = 1'b0;
         end
      end else if (offer_v && ecnt_ff < selm_pkg::RESULT_CAP) begin
         if (pend_v_ff) begin
            push = 1'b1;
         end
         pend_in   = offer_item;
         pend_v_in = 1'b1;
         ecnt_in   = ecnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         pend_v_ff <= 1'b0;
         ecnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pend_v_ff <= pend_v_in;
         ecnt_ff   <= ecnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      txn_ff    <= txn_in;
      key_ff    <= key_in;
      scan_ff   <= scan_in;
      fslot_ff  <= fslot_in;
      free_ff   <= free_in;
      found_ff  <= found_in;
      free_v_ff <= free_v_in;
      cnt_ff    <= cnt_in;
      idx_ff    <= idx_in;
      widx_ff   <= widx_in;
      base_ff   <= base_in;
      ok_ff     <= ok_in;
      sh_ff     <= sh_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      pend_ff   <= pend_in;
   end

   selm_rsp_stage u_rsp (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .item          (push_item),
      .can_push      (can_push),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_granted   (rsp_granted),
      .rsp_owner_txn (rsp_owner_txn),
      .rsp_lock_mode (rsp_lock_mode),
      .rsp_error     (rsp_error),
      .rsp_last      (rsp_last)
   );

endmodule

[hw/rtl/selm_rsp_stage.sv]
// ----------------------------------------------------------------------------
// selm_rsp_stage
// output register of the response channel
// ----------------------------------------------------------------------------
module selm_rsp_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  selm_pkg::item_type          item,
   output logic                        can_push,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_kind,
   output logic                        rsp_granted,
   output logic [selm_pkg::TXN_W-1:0]  rsp_owner_txn,
   output logic [1:0]                  rsp_lock_mode,
   output logic [1:0]                  rsp_error,
   output logic                        rsp_last
);

   logic               valid_ff;
   selm_pkg::item_type data_ff;

   assign can_push = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= item;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_kind      = data_ff.kind;
   assign rsp_granted   = data_ff.granted;
   assign rsp_owner_txn = data_ff.owner;
   assign rsp_lock_mode = data_ff.mode;
   assign rsp_error     = data_ff.err;
   assign rsp_last      = data_ff.last;

endmodule

[hw/rtl/selm_checker.sv]
// ----------------------------------------------------------------------------
// selm_checker
// port-level checks of the lock manager response channel
// ----------------------------------------------------------------------------
`include "shared_exclusive_lock_manager_unit_defines.svh"

module selm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [1:0]                  rsp_kind,
   input logic                        rsp_granted,
   input logic [selm_pkg::TXN_W-1:0]  rsp_owner_txn,
   input logic [1:0]                  rsp_lock_mode,
   input logic [1:0]                  rsp_error,
   input logic                        rsp_last
);

   `SELM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_owner_txn) && $stable(rsp_last), "stalled response changed")
   `SELM_ASSERT_IMP(a_lock_last, clock, reset, rsp_valid && rsp_kind == selm_pkg::KIND_LOCK, rsp_last && rsp_lock_mode == selm_pkg::MODE_NONE, "lock reply not single")
   `SELM_ASSERT_IMP(a_err_deny, clock, reset, rsp_valid && rsp_kind == selm_pkg::KIND_LOCK && rsp_error != selm_pkg::ERR_OK, !rsp_granted, "refused request granted")
   `SELM_ASSERT_IMP(a_ready_clean, clock, reset, rsp_valid && rsp_kind == selm_pkg::KIND_READY, !rsp_granted && rsp_error == selm_pkg::ERR_OK && rsp_lock_mode == selm_pkg::MODE_NONE, "ready notice carries reply fields")

endmodule

bind shared_exclusive_lock_manager_unit selm_checker u_selm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_granted   (rsp_granted),
   .rsp_owner_txn (rsp_owner_txn),
   .rsp_lock_mode (rsp_lock_mode),
   .rsp_error     (rsp_error),
   .rsp_last      (rsp_last)
);

[verif/tb_shared_exclusive_lock_manager_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_exclusive_lock_manager_unit
// checks lock replies, ready notices and status entries of the lock manager
// against a behavioral lock table kept inside the testbench
// ----------------------------------------------------------------------------
module tb_shared_exclusive_lock_manager_unit;

   localparam int KEYS  = 16;
   localparam int DEPTH = 8;
   localparam int TXNS  = 64;
   localparam int CAP   = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_cmd;
   logic [selm_pkg::TXN_W-1:0]    req_txn_id;
   logic [selm_pkg::KEY_W-1:0]    req_lock_key;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [1:0]                    rsp_kind;
   logic                          rsp_granted;
   logic [selm_pkg::TXN_W-1:0]    rsp_owner_txn;
   logic [1:0]                    rsp_lock_mode;
   logic [1:0]                    rsp_error;
   logic                          rsp_last;

   shared_exclusive_lock_manager_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_txn_id(req_txn_id), .req_lock_key(req_lock_key),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_granted(rsp_granted), .rsp_owner_txn(rsp_owner_txn),
      .rsp_lock_mode(rsp_lock_mode), .rsp_error(rsp_error), .rsp_last(rsp_last)
   );

   // lock table mirror
   logic                          tbl_used  [KEYS];
   logic [selm_pkg::KEY_W-1:0]    tbl_key   [KEYS];
   int                            tbl_len   [KEYS];
   selm_pkg::qentry_type          tbl_queue [KEYS][DEPTH];
   logic [selm_pkg::WAIT_W-1:0]   txn_waits [TXNS];

   selm_pkg::item_type expected_responses[$];
   selm_pkg::item_type step_out[$];
   int  failures;
   int  cycle_count;
   bit  idle_enable;

   // key pool kept small so requests collide
   logic [selm_pkg::KEY_W-1:0] key_pool[20];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // prediction
   // --------------------------------------------------------------------------
   function automatic int lookup_slot(logic [selm_pkg::KEY_W-1:0] k);
      for (int i = 0; i < KEYS; i++)
         if (tbl_used[i] && tbl_key[i] == k) return i;
      return -1;
   endfunction

   // holders: front exclusive entry, or leading run of shared entries
   function automatic void find_holders(int s, output bit held[DEPTH]);
      for (int i = 0; i < DEPTH; i++) held[i] = 0;
      if (tbl_len[s] == 0) return;
      if (tbl_queue[s][0].excl) begin
         held[0] = 1;
         return;
      end
      for (int i = 0; i < tbl_len[s] && !tbl_queue[s][i].excl; i++) held[i] = 1;
   endfunction

   function automatic void emit(logic [1:0] kind, logic gr,
                                logic [selm_pkg::TXN_W-1:0] own,
                                logic [1:0] mode, logic [1:0] err);
      selm_pkg::item_type it;
      if (step_out.size() >= CAP) return;   // results past the cap are dropped
      it = '{kind: kind, granted: gr, owner: own, mode: mode, err: err, last: 1'b0};
      step_out.insert(step_out.size(), it);
   endfunction

   function automatic void predict_lock(logic [selm_pkg::TXN_W-1:0] txn,
                                        logic [selm_pkg::KEY_W-1:0] k, logic excl);
      int s;
      bit ok;
      selm_pkg::qentry_type e;
      s = lookup_slot(k);
      e.excl = excl;
      e.txn = txn;
      if (s < 0) begin
         for (int i = 0; i < KEYS; i++)
            if (!tbl_used[i]) begin s = i; break; end
         if (s < 0) begin
            emit(selm_pkg::KIND_LOCK, 1'b0, txn, selm_pkg::MODE_NONE,
                 selm_pkg::ERR_TABLE_FULL);
            return;
         end
         tbl_used[s] = 1; tbl_key[s] = k; tbl_len[s] = 1; tbl_queue[s][0] = e;
         emit(selm_pkg::KIND_LOCK, 1'b1, txn, selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
         return;
      end
      if (tbl_len[s] >= DEPTH) begin
         emit(selm_pkg::KIND_LOCK, 1'b0, txn, selm_pkg::MODE_NONE,
              selm_pkg::ERR_QUEUE_FULL);
         return;
      end
      ok = !excl;
      for (int i = 0; i < tbl_len[s]; i++) if (tbl_queue[s][i].excl) ok = 0;
      tbl_queue[s][tbl_len[s]] = e;
      tbl_len[s]++;
      if (!ok && txn_waits[txn] != selm_pkg::WAIT_MAX) txn_waits[txn]++;
      emit(selm_pkg::KIND_LOCK, ok, txn, selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
   endfunction

   function automatic void predict_release(logic [selm_pkg::TXN_W-1:0] txn,
                                           logic [selm_pkg::KEY_W-1:0] k);
      int s, w;
      bit was_held[DEPTH], now_held[DEPTH], kept_held[DEPTH];
      logic [selm_pkg::TXN_W-1:0] t;
      s = lookup_slot(k);
      if (s < 0) return;
      find_holders(s, was_held);
      w = 0;
      for (int r = 0; r < tbl_len[s]; r++)
         if (tbl_queue[s][r].txn != txn) begin
            tbl_queue[s][w] = tbl_queue[s][r];
            kept_held[w] = was_held[r];
            w++;
         end
      tbl_len[s] = w;
      if (w == 0) begin
         tbl_used[s] = 0;
         return;
      end
      find_holders(s, now_held);
      // only requests that just became holders lower their wait count
      for (int i = 0; i < w; i++) begin
         if (!now_held[i] || kept_held[i]) continue;
         t = tbl_queue[s][i].txn;
         if (txn_waits[t] != 0) begin
            txn_waits[t]--;
            if (txn_waits[t] == 0)
               emit(selm_pkg::KIND_READY, 1'b0, t, selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
         end
      end
   endfunction

   function automatic void predict_status(logic [selm_pkg::KEY_W-1:0] k);
      int s;
      s = lookup_slot(k);
      if (s < 0 || tbl_len[s] == 0) begin
         emit(selm_pkg::KIND_STATUS, 1'b0, '0, selm_pkg::MODE_NONE, selm_pkg::ERR_OK);
         return;
      end
      if (tbl_queue[s][0].excl) begin
         emit(selm_pkg::KIND_STATUS, 1'b0, tbl_queue[s][0].txn, selm_pkg::MODE_EXCL,
              selm_pkg::ERR_OK);
         return;
      end
      for (int i = 0; i < tbl_len[s] && !tbl_queue[s][i].excl; i++)
         emit(selm_pkg::KIND_STATUS, 1'b0, tbl_queue[s][i].txn, selm_pkg::MODE_SHARED,
              selm_pkg::ERR_OK);
   endfunction

   function automatic void predict_request(logic [1:0] cmd,
                                           logic [selm_pkg::TXN_W-1:0] txn,
                                           logic [selm_pkg::KEY_W-1:0] k);
      step_out.delete();
      case (cmd)
         selm_pkg::CMD_READ:    predict_lock(txn, k, 1'b0);
         selm_pkg::CMD_WRITE:   predict_lock(txn, k, 1'b1);
         selm_pkg::CMD_RELEASE: predict_release(txn, k);
         default:               predict_status(k);
      endcase
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_responses.insert(expected_responses.size(), step_out[i]);
   endfunction

   // --------------------------------------------------------------------------
   // request driver
   // --------------------------------------------------------------------------
   task automatic send_request(logic [1:0] cmd, logic [selm_pkg::TXN_W-1:0] txn,
                               logic [selm_pkg::KEY_W-1:0] k);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_txn_id   <= txn;
      req_lock_key <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(cmd, txn, k);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (expected_responses.size() > 0) @(posedge clock);
      repeat (2 * KEYS + 2 * DEPTH + 3 * CAP + 20) @(posedge clock);
   endtask

   // --------------------------------------------------------------------------
   // response checker and receiver stalls
   // --------------------------------------------------------------------------
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 6);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      selm_pkg::item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_responses.size() == 0) begin
            $error("unexpected response kind=%0d owner=%0d", rsp_kind, rsp_owner_txn);
            failures++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind expected %0d actual %0d", want.kind, rsp_kind); failures++;
            end
            if (rsp_granted !== want.granted) begin
               $error("granted expected %0d actual %0d", want.granted, rsp_granted);
               failures++;
            end
            if (rsp_owner_txn !== want.owner) begin
               $error("owner_txn expected %0d actual %0d", want.owner, rsp_owner_txn);
               failures++;
            end
            if (rsp_lock_mode !== want.mode) begin
               $error("lock_mode expected %0d actual %0d", want.mode, rsp_lock_mode);
               failures++;
            end
            if (rsp_error !== want.err) begin
               $error("error expected %0d actual %0d", want.err, rsp_error); failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_last); failures++;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // tests
   // --------------------------------------------------------------------------
   function automatic logic [selm_pkg::KEY_W-1:0] pick_key();
      return key_pool[$urandom_range(0, 19)];
   endfunction

   // extremes of the fields, shared/exclusive queueing, ready notices, status
   task automatic test_directed();
      send_request(selm_pkg::CMD_STATUS, 6'd0, 32'hFFFF_FFFF);     // absent key
      send_request(selm_pkg::CMD_RELEASE, 6'd5, 32'hFFFF_FFFF);    // absent release
      send_request(selm_pkg::CMD_READ, 6'd0, 32'h0000_0000);
      send_request(selm_pkg::CMD_READ, 6'd63, 32'h0000_0000);
      send_request(selm_pkg::CMD_READ, 6'd0, 32'h0000_0000);       // duplicate
      send_request(selm_pkg::CMD_WRITE, 6'd7, 32'h0000_0000);      // waits
      send_request(selm_pkg::CMD_READ, 6'd8, 32'h0000_0000);       // waits behind write
      send_request(selm_pkg::CMD_STATUS, 6'd1, 32'h0000_0000);     // shared owners
      send_request(selm_pkg::CMD_RELEASE, 6'd9, 32'h0000_0000);    // txn with no requests
      send_request(selm_pkg::CMD_RELEASE, 6'd0, 32'h0000_0000);
      send_request(selm_pkg::CMD_RELEASE, 6'd63, 32'h0000_0000);   // writer becomes ready
      send_request(selm_pkg::CMD_STATUS, 6'd0, 32'h0000_0000);     // exclusive
      send_request(selm_pkg::CMD_RELEASE, 6'd7, 32'h0000_0000);    // reader ready
      send_request(selm_pkg::CMD_RELEASE, 6'd8, 32'h0000_0000);    // key freed
      send_request(selm_pkg::CMD_WRITE, 6'd63, 32'hFFFF_FFFF);
      // queue full on one key
      for (int i = 0; i < DEPTH; i++)
         send_request(selm_pkg::CMD_WRITE, 6'(i + 1), 32'hFFFF_FFFF);
      send_request(selm_pkg::CMD_RELEASE, 6'd63, 32'hFFFF_FFFF);
      drain_responses();
   endtask

   // fill the key table until requests are refused
   task automatic test_table_full();
      for (int i = 0; i < KEYS + 2; i++)
         send_request(selm_pkg::CMD_READ, 6'd3, 32'h1000 + i);
      send_request(selm_pkg::CMD_STATUS, 6'd0, 32'h1000);
      for (int i = 0; i < KEYS + 2; i++)
         send_request(selm_pkg::CMD_RELEASE, 6'd3, 32'h1000 + i);
      drain_responses();
   endtask

   // wait counts saturate at their maximum
   task automatic test_wait_saturation();
      send_request(selm_pkg::CMD_WRITE, 6'd1, 32'hABCD_0000);
      for (int i = 0; i < 18; i++)
         send_request(selm_pkg::CMD_WRITE, 6'd2, 32'hABCD_0100 + (i % 3));
      for (int i = 0; i < 3; i++)
         send_request(selm_pkg::CMD_WRITE, 6'd4, 32'hABCD_0100 + i);
      for (int i = 0; i < 3; i++)
         send_request(selm_pkg::CMD_RELEASE, 6'd4, 32'hABCD_0100 + i);
      for (int i = 0; i < 3; i++)
         send_request(selm_pkg::CMD_RELEASE, 6'd2, 32'hABCD_0100 + i);
      send_request(selm_pkg::CMD_RELEASE, 6'd1, 32'hABCD_0000);
      drain_responses();
   endtask

   // mostly well-formed lock, release and status traffic on a small key pool
   task automatic test_random(int count);
      int r;
      logic [1:0] cmd;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 35)      cmd = selm_pkg::CMD_READ;
         else if (r < 60) cmd = selm_pkg::CMD_WRITE;
         else if (r < 88) cmd = selm_pkg::CMD_RELEASE;
         else             cmd = selm_pkg::CMD_STATUS;
         send_request(cmd, 6'($urandom_range(0, 11) == 0 ? $urandom_range(0, 63)
                                                        : $urandom_range(0, 7)),
                      $urandom_range(0, 15) == 0 ? $urandom() : pick_key());
         if (i == count / 2) drain_responses();   // sender holds off until drained
      end
   endtask

   // release txns 0 to 7 on every pool key that is still in the table
   task automatic test_cleanup();
      for (int k = 0; k < 20; k++)
         for (int t = 0; t < 8; t++)
            if (lookup_slot(key_pool[k]) >= 0)
               send_request(selm_pkg::CMD_RELEASE, 6'(t), key_pool[k]);
   endtask

   initial begin
      failures     = 0;
      cycle_count  = 0;
      idle_enable  = 1'b1;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = selm_pkg::CMD_READ;
      req_txn_id   = '0;
      req_lock_key = '0;
      for (int i = 0; i < KEYS; i++) begin
         tbl_used[i] = 0; tbl_len[i] = 0; tbl_key[i] = '0;
      end
      for (int i = 0; i < TXNS; i++) txn_waits[i] = '0;
      for (int i = 0; i < 20; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0; key_pool[1] = 32'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_wait_saturation();
      test_random(190);
      idle_enable = 1'b0;                 // last stretch runs flat out
      test_random(40);
      test_cleanup();

      drain_responses();
      if (failures == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
